@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the reprojection module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication under the active-low reset.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication under the active-low reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/dpr_pkg.sv @@
`timescale 1ns / 1ps
package dpr_pkg;
    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_COL_OFFSET   = 3'd0,
        REG_ROW_OFFSET   = 3'd1,
        REG_FOCAL        = 3'd2,
        REG_INV_BASELINE = 3'd3,
        REG_W_OFFSET     = 3'd4
    } t_reg_idx;

    // One input pixel.
    typedef struct packed {
        logic [10:0] column;
        logic [10:0] row;
        logic [7:0]  disparity;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } t_pix;

    // One reprojected point.
    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [23:0]        packed_color;
        logic               overflow;
    } t_point;

    // Saturation limits of signed Q16.16.
    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;
endpackage

@@ hw/rtl/dpr_if.sv @@
`timescale 1ns / 1ps
// Pixel channel.
interface dpr_pix_if;
    logic          valid;
    logic          ready;
    dpr_pkg::t_pix data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Point channel.
interface dpr_pt_if;
    logic            valid;
    logic            ready;
    dpr_pkg::t_point data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Configuration write channel.
interface dpr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/disparity_to_point_reprojection.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Reprojects a stream of disparity pixels to colored 3-D points.
// i_pix carries one pixel item (column, row, disparity, color bytes) per
// valid/ready handshake; o_pt gives one point item for every pixel with a
// nonzero disparity inside the image, in input order. Other pixels vanish.
// i_cfg writes the five reprojection terms by index; it is always ready and
// an unknown index is ignored. Write it only while no item is in flight.
// Throughput is one item per cycle while o_pt is not stalled. From accept
// to o_pt.valid the item passes 37 registers and the first loads at the
// accepting edge. They are an input register, a multiply stage, a divisor
// stage, a setup stage, 32 restoring-division stages (one quotient bit each,
// three lanes sharing the divisor) and the saturating output register.
// When o_pt is stalled with a point waiting, the whole pipeline holds and
// i_pix.ready falls; nothing is lost or repeated. Reset clears the valid
// bits of every stage and all terms to zero.
module disparity_to_point_reprojection #(
    parameter int MAX_COLUMNS = 2048,
    parameter int MAX_ROWS    = 2048
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dpr_pix_if.sink         i_pix,
    dpr_cfg_if.sink         i_cfg,
    dpr_pt_if.source        o_pt
);
    localparam int QB = 32;           // quotient bits
    localparam int NS = QB + 1;       // remainder stage count incl. setup
    localparam int DW = 41;           // divisor magnitude width
    localparam int NW = 34;           // numerator magnitude width
    localparam int RW = DW + QB - 1;  // remainder width

    logic signed [31:0] r_q03, r_q13, r_q23, r_q32, r_q33;
    logic en;

    assign en          = !o_pt.valid || o_pt.ready;
    assign i_pix.ready = en;
    assign i_cfg.ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q03 <= '0; r_q13 <= '0; r_q23 <= '0; r_q32 <= '0; r_q33 <= '0;
        end else if (i_cfg.valid) begin
            unique case (dpr_pkg::t_reg_idx'(i_cfg.index))
                dpr_pkg::REG_COL_OFFSET:   r_q03 <= i_cfg.data;
                dpr_pkg::REG_ROW_OFFSET:   r_q13 <= i_cfg.data;
                dpr_pkg::REG_FOCAL:        r_q23 <= i_cfg.data;
                dpr_pkg::REG_INV_BASELINE: r_q32 <= i_cfg.data;
                dpr_pkg::REG_W_OFFSET:     r_q33 <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Stage A: register the pixel and whether it yields a point.
    logic r_va;
    dpr_pkg::t_pix r_a;
    logic n_va;
    assign n_va = i_pix.valid && (i_pix.data.disparity != 8'd0)
        && (17'(i_pix.data.column) < 17'(MAX_COLUMNS))
        && (17'(i_pix.data.row) < 17'(MAX_ROWS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_va <= 1'b0;
        else if (en) r_va <= n_va;
    end
    always_ff @(posedge i_clk) begin
        if (en) r_a <= i_pix.data;
    end

    // Stage B: disparity product and numerators.
    logic r_vb;
    logic signed [40:0] r_b_prod;
    logic signed [NW-1:0] r_b_num [3];
    logic [23:0] r_b_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vb <= 1'b0;
        else if (en) r_vb <= r_va;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_prod   <= 41'($signed({1'b0, r_a.disparity})) * 41'(r_q32);
            r_b_num[0] <= $signed({7'd0, r_a.column, 16'd0}) + NW'(r_q03);
            r_b_num[1] <= $signed({7'd0, r_a.row, 16'd0}) + NW'(r_q13);
            r_b_num[2] <= NW'(r_q23);
            r_b_col    <= {r_a.red, r_a.green, r_a.blue};
        end
    end

    // Stage C: divisor and sign-magnitude split.
    logic r_vc;
    logic [DW-1:0] r_c_d;
    logic r_c_wz;
    logic [NW-1:0] r_c_n [3];
    logic [2:0] r_c_neg;
    logic [23:0] r_c_col;
    logic signed [41:0] w;
    assign w = 42'(r_q33) - 42'(r_b_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vc <= 1'b0;
        else if (en) r_vc <= r_vb;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_d   <= DW'(w[41] ? -w : w);
            r_c_wz  <= (w == '0);
            r_c_col <= r_b_col;
            for (int l = 0; l < 3; l++) begin
                r_c_n[l]   <= r_b_num[l][NW-1] ? NW'(-r_b_num[l]) : NW'(r_b_num[l]);
                r_c_neg[l] <= r_b_num[l][NW-1] ^ w[41];
            end
        end
    end

    // Division pipeline; stage 0 is the setup with the overflow precheck.
    logic [NS:0]   r_v;
    logic [RW-1:0] r_rem [NS][3];
    logic [QB-1:0] r_q   [NS][3];
    logic [2:0]    r_ovf [NS];
    logic [2:0]    r_neg [NS];
    logic [DW-1:0] r_d   [NS];
    logic          r_wz  [NS];
    logic [23:0]   r_col [NS];

    // Valid bits of the division stages and of the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (en) r_v <= {r_v[NS-1:0], r_vc};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d[0]   <= r_c_d;
            r_wz[0]  <= r_c_wz;
            r_neg[0] <= r_c_neg;
            r_col[0] <= r_c_col;
            for (int l = 0; l < 3; l++) begin
                r_rem[0][l] <= RW'({r_c_n[l], 24'd0});
                r_q[0][l]   <= '0;
                r_ovf[0][l] <= {15'd0, r_c_n[l]} >= {r_c_d, 8'd0};
            end
        end
    end

    for (genvar s = 1; s < NS; s++) begin : g_div
        // One quotient bit per stage, most significant first.
        localparam int B = QB - s;
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_d[s]   <= r_d[s-1];
                r_wz[s]  <= r_wz[s-1];
                r_neg[s] <= r_neg[s-1];
                r_ovf[s] <= r_ovf[s-1];
                r_col[s] <= r_col[s-1];
                for (int l = 0; l < 3; l++) begin
                    if (r_rem[s-1][l] >= (RW'(r_d[s-1]) << B)) begin
                        r_rem[s][l] <= r_rem[s-1][l] - (RW'(r_d[s-1]) << B);
                        r_q[s][l]   <= r_q[s-1][l] | (QB'(1) << B);
                    end else begin
                        r_rem[s][l] <= r_rem[s-1][l];
                        r_q[s][l]   <= r_q[s-1][l];
                    end
                end
            end
        end
    end

    // Output register: sign, saturation and the zero-divisor case.
    logic [31:0] n_pt [3];
    logic [2:0]  n_sat;
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_sat[l] = 1'b0;
            if (r_q[NS-1][l] == '0 && !r_ovf[NS-1][l]) begin
                n_pt[l] = '0;
            end else if (r_neg[NS-1][l]) begin
                n_sat[l] = r_ovf[NS-1][l] || (r_q[NS-1][l] > dpr_pkg::SAT_NEG);
                n_pt[l]  = n_sat[l] ? dpr_pkg::SAT_NEG : -r_q[NS-1][l];
            end else begin
                n_sat[l] = r_ovf[NS-1][l] || r_q[NS-1][l][31];
                n_pt[l]  = n_sat[l] ? dpr_pkg::SAT_POS : r_q[NS-1][l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_pt.data.point_x      <= r_wz[NS-1] ? '0 : n_pt[0];
            o_pt.data.point_y      <= r_wz[NS-1] ? '0 : n_pt[1];
            o_pt.data.point_z      <= r_wz[NS-1] ? '0 : n_pt[2];
            o_pt.data.packed_color <= r_col[NS-1];
            o_pt.data.overflow     <= r_wz[NS-1] || (n_sat != 3'd0);
        end
    end
    assign o_pt.valid = r_v[NS];

    // Checks.
    `ASSERT_NOW(a_ready_stall, i_clk, i_rst_n, o_pt.valid && !o_pt.ready, !i_pix.ready)
    `ASSERT_NEXT(a_drop_zero, i_clk, i_rst_n,
        i_pix.valid && i_pix.ready && i_pix.data.disparity == 8'd0, !r_va)
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, !en, $stable(r_v))
endmodule
